@@ src/wgb_pkg.sv @@
package wgb_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int MAX_GROUP_DEF   = 32;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	localparam logic [5:0]  MAX_REQ_RESET   = 6'd16;
	localparam logic [23:0] MAX_BYTES_RESET = 24'd1048576;

	localparam logic REG_MAX_REQUESTS = 1'b0;
	localparam logic REG_MAX_BYTES    = 1'b1;

	localparam logic [1:0] OP_ENQUEUE    = 2'd0;
	localparam logic [1:0] OP_GROUP_DONE = 2'd1;
	localparam logic [1:0] OP_SHUTDOWN   = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FAIL     = 2'd1;
	localparam logic [1:0] STAT_SHUTDOWN = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	localparam logic KIND_DISPATCH = 1'b0;
	localparam logic KIND_COMPLETE = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  request_id;
		logic        sync_flag;
		logic [23:0] req_size;
		logic        done_status;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  result_id;
		logic        result_sync;
		logic [1:0]  result_status;
		logic        last_of_run;
	} result_t;

	typedef enum logic [1:0] {
		CMD_ENQUEUE    = 2'd0,
		CMD_REJECT     = 2'd1,
		CMD_GROUP_DONE = 2'd2,
		CMD_SHUTDOWN   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  id;
		logic        sync;
		logic [23:0] bytes;
		logic        status;
	} cmd_t;

endpackage

@@ src/wgb_front.sv @@
module wgb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  wgb_pkg::item_t req,
	input  logic           cmdq_full,
	output logic           cmd_push,
	output wgb_pkg::cmd_t  cmd
);

	logic shut_q;
	logic accept;
	logic known_op;

	assign req_stall = cmdq_full;
	assign accept    = req_valid && !cmdq_full;

	always_comb begin
		known_op   = 1'b1;
		cmd.id     = req.request_id;
		cmd.sync   = req.sync_flag;
		cmd.bytes  = req.req_size;
		cmd.status = req.done_status;
		cmd.kind   = wgb_pkg::CMD_ENQUEUE;
		case (req.opcode)
			wgb_pkg::OP_ENQUEUE: begin
				// once shutdown is seen, every later enqueue is a reject
				cmd.kind = shut_q ? wgb_pkg::CMD_REJECT : wgb_pkg::CMD_ENQUEUE;
			end
			wgb_pkg::OP_GROUP_DONE: cmd.kind = wgb_pkg::CMD_GROUP_DONE;
			wgb_pkg::OP_SHUTDOWN:   cmd.kind = wgb_pkg::CMD_SHUTDOWN;
			default:                known_op = 1'b0;
		endcase
	end

	// drop unknown opcodes after accepting them
	assign cmd_push = accept && known_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shut_q <= 1'b0;
		end else if (accept && req.opcode == wgb_pkg::OP_SHUTDOWN) begin
			shut_q <= 1'b1;
		end
	end

endmodule

@@ src/wgb_cmdq.sv @@
module wgb_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wgb_pkg::cmd_t push_data,
	output logic          full,
	output logic          valid,
	output wgb_pkg::cmd_t data,
	input  logic          pop
);

	wgb_pkg::cmd_t                  entry_q [wgb_pkg::CMDQ_DEPTH];
	logic [wgb_pkg::CMDQ_AW-1:0]    wptr_q;
	logic [wgb_pkg::CMDQ_AW-1:0]    rptr_q;
	logic [wgb_pkg::CMDQ_CW-1:0]    cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (cnt_q == wgb_pkg::CMDQ_CW'(wgb_pkg::CMDQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign data    = entry_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule

@@ src/wgb_back.sv @@
module wgb_back #(
	parameter int QUEUE_DEPTH = wgb_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_GROUP   = wgb_pkg::MAX_GROUP_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [5:0]       max_req,
	input  logic [23:0]      max_bytes,
	input  logic             cmd_valid,
	input  wgb_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output wgb_pkg::result_t rsp
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int GAW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int GSW = $clog2(MAX_GROUP + 1);

	typedef struct packed {
		logic [7:0]  id;
		logic        sync;
		logic [23:0] bytes;
	} entry_t;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_FORM_RD   = 8'b0000_0010,
		S_FORM_CHK  = 8'b0000_0100,
		S_DONE_RD   = 8'b0000_1000,
		S_DONE_EMIT = 8'b0001_0000,
		S_SHUT_RD   = 8'b0010_0000,
		S_SHUT_EMIT = 8'b0100_0000,
		S_FLUSH     = 8'b1000_0000
	} state_t;

	function automatic wgb_pkg::result_t mk_result(
		input logic       kind,
		input logic [7:0] id,
		input logic       sync,
		input logic [1:0] status
	);
		wgb_pkg::result_t r;
		r.result_kind   = kind;
		r.result_id     = id;
		r.result_sync   = sync;
		r.result_status = status;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	entry_t           pmem [QUEUE_DEPTH];
	logic [7:0]       gmem [MAX_GROUP];
	entry_t           prd_q;
	logic [7:0]       grd_q;

	state_t           state_q, state_d;
	logic [QAW-1:0]   head_q, head_d, head_next, tail;
	logic [CW-1:0]    count_q, count_d, count_m1;
	logic [CW:0]      tsum;
	logic [GSW-1:0]   gsize_q, gsize_d, gsize_inc;
	logic [GSW-1:0]   idx_q, idx_d, idx_inc;
	logic [GSW-1:0]   lim;
	logic             in_flight_q, in_flight_d;
	logic             shut_q, shut_d;
	logic [23:0]      total_q, total_d;
	logic [24:0]      sum;
	logic             gsync_q, gsync_d;
	logic [1:0]       dstat_q, dstat_d;
	logic             admit;

	logic             p_wr, p_rd, g_wr, g_rd;
	logic             emit, flush;
	wgb_pkg::result_t new_res;
	wgb_pkg::result_t pend_q;
	logic             pend_v_q;
	wgb_pkg::result_t out_q;
	wgb_pkg::result_t out_d;
	logic             out_v_q;
	logic             slot_free, can_emit, load_out;

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;
	assign slot_free = !out_v_q || !rsp_stall;
	assign can_emit  = !pend_v_q || slot_free;
	assign load_out  = (emit && pend_v_q) || flush;

	assign head_next = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign count_m1  = count_q - 1'b1;
	assign tsum      = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail      = (tsum >= (CW+1)'(QUEUE_DEPTH)) ?
		QAW'(tsum - (CW+1)'(QUEUE_DEPTH)) : QAW'(tsum);
	assign gsize_inc = gsize_q + 1'b1;
	assign idx_inc   = idx_q + 1'b1;
	assign sum       = {1'b0, total_q} + {1'b0, prd_q.bytes};

	// zero acts as one, anything above the group store acts as its size
	always_comb begin
		if (max_req == '0) begin
			lim = GSW'(1);
		end else if ({1'b0, max_req} > 7'(MAX_GROUP)) begin
			lim = GSW'(MAX_GROUP);
		end else begin
			lim = GSW'(max_req);
		end
	end

	// the first member is always taken; the rest must match sync and fit
	assign admit = (gsize_q == '0) ||
		(prd_q.sync == gsync_q && sum <= {1'b0, max_bytes});

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		gsize_d     = gsize_q;
		idx_d       = idx_q;
		in_flight_d = in_flight_q;
		shut_d      = shut_q;
		total_d     = total_q;
		gsync_d     = gsync_q;
		dstat_d     = dstat_q;
		cmd_pop     = 1'b0;
		p_wr        = 1'b0;
		p_rd        = 1'b0;
		g_wr        = 1'b0;
		g_rd        = 1'b0;
		emit        = 1'b0;
		flush       = 1'b0;
		new_res     = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						wgb_pkg::CMD_ENQUEUE: begin
							if (count_q == CW'(QUEUE_DEPTH)) begin
								emit    = 1'b1;
								new_res = mk_result(wgb_pkg::KIND_COMPLETE, cmd.id,
									1'b0, wgb_pkg::STAT_FULL);
								state_d = S_FLUSH;
							end else begin
								p_wr    = 1'b1;
								count_d = count_q + 1'b1;
								if (!in_flight_q) begin
									in_flight_d = 1'b1;
									gsize_d     = '0;
									total_d     = '0;
									state_d     = S_FORM_RD;
								end
							end
						end
						wgb_pkg::CMD_REJECT: begin
							emit    = 1'b1;
							new_res = mk_result(wgb_pkg::KIND_COMPLETE, cmd.id,
								1'b0, wgb_pkg::STAT_SHUTDOWN);
							state_d = S_FLUSH;
						end
						wgb_pkg::CMD_GROUP_DONE: begin
							if (in_flight_q) begin
								idx_d   = '0;
								dstat_d = {1'b0, cmd.status};
								state_d = S_DONE_RD;
							end
						end
						wgb_pkg::CMD_SHUTDOWN: begin
							shut_d = 1'b1;
							if (count_q != '0) begin
								state_d = S_SHUT_RD;
							end
						end
						default: ;
					endcase
				end
			end
			S_FORM_RD: begin
				p_rd    = 1'b1;
				state_d = S_FORM_CHK;
			end
			S_FORM_CHK: begin
				if (!admit) begin
					state_d = S_FLUSH;
				end else if (can_emit) begin
					emit    = 1'b1;
					new_res = mk_result(wgb_pkg::KIND_DISPATCH, prd_q.id,
						prd_q.sync, wgb_pkg::STAT_OK);
					g_wr    = 1'b1;
					gsize_d = gsize_inc;
					total_d = sum[23:0];
					gsync_d = prd_q.sync;
					head_d  = head_next;
					count_d = count_m1;
					if (count_m1 != '0 && gsize_inc < lim) begin
						state_d = S_FORM_RD;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_DONE_RD: begin
				g_rd    = 1'b1;
				state_d = S_DONE_EMIT;
			end
			S_DONE_EMIT: begin
				if (can_emit) begin
					emit    = 1'b1;
					new_res = mk_result(wgb_pkg::KIND_COMPLETE, grd_q, 1'b0, dstat_q);
					idx_d   = idx_inc;
					if (idx_inc < gsize_q) begin
						state_d = S_DONE_RD;
					end else if (count_q != '0 && !shut_q) begin
						// next group follows in the same run
						in_flight_d = 1'b1;
						gsize_d     = '0;
						total_d     = '0;
						state_d     = S_FORM_RD;
					end else begin
						in_flight_d = 1'b0;
						gsize_d     = '0;
						state_d     = S_FLUSH;
					end
				end
			end
			S_SHUT_RD: begin
				p_rd    = 1'b1;
				state_d = S_SHUT_EMIT;
			end
			S_SHUT_EMIT: begin
				if (can_emit) begin
					emit    = 1'b1;
					new_res = mk_result(wgb_pkg::KIND_COMPLETE, prd_q.id,
						1'b0, wgb_pkg::STAT_SHUTDOWN);
					head_d  = head_next;
					count_d = count_m1;
					state_d = (count_m1 != '0) ? S_SHUT_RD : S_FLUSH;
				end
			end
			S_FLUSH: begin
				// release the held result as the last of this run
				if (slot_free) begin
					flush   = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		out_d             = pend_q;
		out_d.last_of_run = flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			gsize_q     <= '0;
			in_flight_q <= 1'b0;
			shut_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			gsize_q     <= gsize_d;
			in_flight_q <= in_flight_d;
			shut_q      <= shut_d;
			if (emit) begin
				pend_v_q <= 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		total_q <= total_d;
		gsync_q <= gsync_d;
		dstat_q <= dstat_d;
		if (emit) begin
			pend_q <= new_res;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk) begin
		if (p_wr) begin
			pmem[tail] <= '{id: cmd.id, sync: cmd.sync, bytes: cmd.bytes};
		end
		if (p_rd) begin
			prd_q <= pmem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (g_wr) begin
			gmem[gsize_q[GAW-1:0]] <= prd_q.id;
		end
		if (g_rd) begin
			grd_q <= gmem[idx_q[GAW-1:0]];
		end
	end

endmodule

@@ src/write_group_batcher_unit.sv @@
// Enqueue to first dispatch: command queue, FIFO write, registered FIFO read, byte check;
// each further member passes through the registered FIFO read ahead of the byte check.
// Group done: each member completion takes a group id store read, then group formation.
// Shutdown: each queued request is read from the FIFO and rejected; rejects and queue-full answers end the run.
// An enqueue behind a group in flight is only written to the FIFO; a two-entry command queue decouples.
// Reset clears control state and loads the register defaults; FIFO contents stay undefined.
module write_group_batcher_unit #(
	parameter int QUEUE_DEPTH = wgb_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_GROUP   = wgb_pkg::MAX_GROUP_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  wgb_pkg::item_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output wgb_pkg::result_t rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [23:0]      cfg_data
);

	logic [5:0]    max_req_q;
	logic [23:0]   max_bytes_q;
	logic          cmdq_full;
	logic          cmd_push;
	wgb_pkg::cmd_t cmd_in;
	logic          cmd_valid;
	wgb_pkg::cmd_t cmd_out;
	logic          cmd_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_q   <= wgb_pkg::MAX_REQ_RESET;
			max_bytes_q <= wgb_pkg::MAX_BYTES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wgb_pkg::REG_MAX_REQUESTS: max_req_q   <= cfg_data[5:0];
				wgb_pkg::REG_MAX_BYTES:    max_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	wgb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmdq_full (cmdq_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	wgb_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (cmdq_full),
		.valid     (cmd_valid),
		.data      (cmd_out),
		.pop       (cmd_pop)
	);

	wgb_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_GROUP   (MAX_GROUP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_req   (max_req_q),
		.max_bytes (max_bytes_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
